@@ design/framebuffer_draw_engine_macros.svh @@
// Assertion helpers shared by the draw engine RTL.
`ifndef FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define FDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds.
`define FDE_NEVER(lbl, cond, msg) \
  `FDE_ASSERT(lbl, !(cond), msg)

`endif

@@ design/fde_pkg.sv @@
package fde_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int GRID_STEP      = 10;
  localparam int DIV_STEPS      = 17;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_PIXEL = 3'd1;
  localparam logic [2:0] ACT_GRID  = 3'd2;
  localparam logic [2:0] ACT_RECT  = 3'd3;
  localparam logic [2:0] ACT_LINE  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        color;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [11:0]        rect_cols;
    logic [11:0]        rect_rows;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_color;
    logic        done_res;
  } out_item_t;

  // Divides a Q.4 value by 16, truncating toward zero.
  function automatic logic signed [13:0] trunc16(input logic signed [17:0] v);
    logic [17:0] m;
    logic [13:0] r;
    m = v[17] ? 18'(-v) : 18'(v);
    r = 14'(m >> 4);
    return v[17] ? $signed(14'(-r)) : $signed(r);
  endfunction

  // Rounds a Q.16 value to an integer, halves away from zero.
  function automatic logic signed [16:0] round_q16(input logic signed [31:0] v);
    logic [32:0] m;
    logic [16:0] r;
    m = v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    r = 17'((m + 33'd32768) >> 16);
    return v[31] ? $signed(17'(-r)) : $signed(r);
  endfunction

endpackage

@@ design/fde_ram.sv @@
module fde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ design/framebuffer_draw_engine.sv @@
// Draw engine over an internal frame store of MAX_WIDTH*MAX_HEIGHT 32-bit words.
// Commands arrive on the in_ channel (valid/ready); each command yields exactly
// one transfer on the out_ channel carrying read_color and done_res.
// cfg_we writes frame_width (index 0) or frame_height (index 1); write them
// only while no command is in flight.
// Per command: pixel writes one word if it falls inside the frame, read
// fetches one word, clear and rectangle write each drawn pixel, grid writes
// each grid dot, and line runs the divider (none when side is 0) and then
// plots side+1 points.
// The frame store takes one write per cycle, which sets the fill rate.
// One command is worked on at a time; a new command is taken while the last
// result still waits in the output register. If the receiver stalls, the
// engine holds the finished result in its final state until the register
// frees. Reset returns to idle with both frame registers at 128; the store
// contents are undefined until drawn.
module framebuffer_draw_engine #(
  parameter int MAX_WIDTH  = fde_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fde_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fde_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fde_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SCAN, ST_DIV, ST_LINE, ST_RD_ADDR, ST_RD_WAIT, ST_FIN
  } state_t;

  state_t             state_r;
  fde_pkg::in_item_t  cmd_r;
  fde_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic [7:0]         fw_r, fh_r;
  logic [8:0]         x_r, y_r, x_lo_r, x_hi_r, y_hi_r;
  logic [3:0]         step_r;
  logic               wr_en_r, rd_ok_r;
  logic [7:0]         op_x_r, op_y_r;
  logic [31:0]        res_color_r;
  logic [12:0]        rem_x_r, rem_y_r;
  logic [16:0]        qx_r, qy_r;
  logic               neg_x_r, neg_y_r;
  logic [11:0]        side_r, cnt_r;
  logic [4:0]         div_cnt_r;
  logic signed [31:0] px_r, py_r, ix_r, iy_r;

  logic [7:0]          w_act, h_act;
  logic signed [13:0]  w14, h14;
  logic signed [17:0]  sx18, sy18;
  logic signed [13:0]  tx, ty, cf, cl, rf, rl, dxf, dyf;
  logic [11:0]         adx, ady, side_c;
  logic                pix_ok, rect_empty;
  logic [8:0]          x_step, y_step;
  logic                ge_x, ge_y;
  logic [12:0]         sub_x, sub_y;
  logic [16:0]         qx_fin, qy_fin;
  logic signed [16:0]  rx, ry;
  logic                line_ok;
  logic [16:0]         addr_sum;
  logic [31:0]         rdata;

  assign w_act = (32'(fw_r) > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : fw_r;
  assign h_act = (32'(fh_r) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : fh_r;
  assign w14   = $signed({6'b0, w_act});
  assign h14   = $signed({6'b0, h_act});

  assign sx18 = 18'(cmd_r.start_x);
  assign sy18 = 18'(cmd_r.start_y);
  assign tx   = fde_pkg::trunc16(sx18);
  assign ty   = fde_pkg::trunc16(sy18);
  assign cf   = tx;
  assign rf   = ty;
  assign cl   = fde_pkg::trunc16(sx18 + $signed({2'b0, 12'(cmd_r.rect_cols - 12'd1), 4'b0}));
  assign rl   = fde_pkg::trunc16(sy18 + $signed({2'b0, 12'(cmd_r.rect_rows - 12'd1), 4'b0}));
  assign dxf  = fde_pkg::trunc16(18'(cmd_r.end_x) - sx18);
  assign dyf  = fde_pkg::trunc16(18'(cmd_r.end_y) - sy18);
  assign adx  = dxf[13] ? 12'(-dxf) : 12'(dxf);
  assign ady  = dyf[13] ? 12'(-dyf) : 12'(dyf);
  assign side_c = (adx >= ady) ? adx : ady;

  assign pix_ok = (tx >= 0) && (tx < w14) && (ty >= 0) && (ty < h14);
  assign rect_empty = (cmd_r.rect_cols == 12'd0) || (cmd_r.rect_rows == 12'd0) ||
                      (w_act == 8'd0) || (h_act == 8'd0) ||
                      (cl < 0) || (cf >= w14) || (rl < 0) || (rf >= h14);

  assign x_step = x_r + {5'b0, step_r};
  assign y_step = y_r + {5'b0, step_r};

  assign ge_x   = rem_x_r >= {1'b0, side_r};
  assign ge_y   = rem_y_r >= {1'b0, side_r};
  assign sub_x  = ge_x ? (rem_x_r - {1'b0, side_r}) : rem_x_r;
  assign sub_y  = ge_y ? (rem_y_r - {1'b0, side_r}) : rem_y_r;
  assign qx_fin = {qx_r[15:0], ge_x};
  assign qy_fin = {qy_r[15:0], ge_y};

  assign rx = fde_pkg::round_q16(px_r);
  assign ry = fde_pkg::round_q16(py_r);
  assign line_ok = (rx >= 0) && (rx < $signed({9'b0, w_act})) &&
                   (ry >= 0) && (ry < $signed({9'b0, h_act}));

  assign addr_sum = 17'(w_act) * 17'(op_y_r) + 17'(op_x_r);

  fde_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (wr_en_r),
    .waddr   (AW'(addr_sum)),
    .wdata   (cmd_r.color),
    .re      ((state_r == ST_RD_ADDR) && rd_ok_r),
    .raddr   (AW'(addr_sum)),
    .rdata_r (rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wr_en_r     <= 1'b0;
      fw_r        <= 8'd128;
      fh_r        <= 8'd128;
    end else begin
      wr_en_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == fde_pkg::REG_WIDTH) begin
          fw_r <= cfg_wdata;
        end else begin
          fh_r <= cfg_wdata;
        end
      end
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          res_color_r <= 32'd0;
          x_r     <= 9'd0;
          y_r     <= 9'd0;
          x_lo_r  <= 9'd0;
          x_hi_r  <= {1'b0, w_act} - 9'd1;
          y_hi_r  <= {1'b0, h_act} - 9'd1;
          step_r  <= 4'd1;
          op_x_r  <= 8'(tx);
          op_y_r  <= 8'(ty);
          rd_ok_r <= pix_ok;
          state_r <= ST_FIN;
          unique case (cmd_r.action)
            fde_pkg::ACT_CLEAR, fde_pkg::ACT_GRID: begin
              if (cmd_r.action == fde_pkg::ACT_GRID) begin
                step_r <= 4'(fde_pkg::GRID_STEP);
              end
              if ((w_act != 8'd0) && (h_act != 8'd0)) begin
                state_r <= ST_SCAN;
              end
            end
            fde_pkg::ACT_PIXEL: begin
              wr_en_r <= pix_ok;
            end
            fde_pkg::ACT_RECT: begin
              x_r    <= cf[13] ? 9'd0 : 9'(cf);
              x_lo_r <= cf[13] ? 9'd0 : 9'(cf);
              y_r    <= rf[13] ? 9'd0 : 9'(rf);
              if (cl < w14) begin
                x_hi_r <= 9'(cl);
              end
              if (rl < h14) begin
                y_hi_r <= 9'(rl);
              end
              if (!rect_empty) begin
                state_r <= ST_SCAN;
              end
            end
            fde_pkg::ACT_LINE: begin
              side_r    <= side_c;
              rem_x_r   <= {1'b0, adx};
              rem_y_r   <= {1'b0, ady};
              qx_r      <= 17'd0;
              qy_r      <= 17'd0;
              neg_x_r   <= dxf[13];
              neg_y_r   <= dyf[13];
              div_cnt_r <= 5'(fde_pkg::DIV_STEPS);
              cnt_r     <= 12'd0;
              ix_r      <= 32'sd0;
              iy_r      <= 32'sd0;
              px_r      <= {{4{cmd_r.start_x[15]}}, cmd_r.start_x, 12'b0};
              py_r      <= {{4{cmd_r.start_y[15]}}, cmd_r.start_y, 12'b0};
              state_r   <= (side_c == 12'd0) ? ST_LINE : ST_DIV;
            end
            fde_pkg::ACT_READ: begin
              state_r <= ST_RD_ADDR;
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          wr_en_r <= 1'b1;
          op_x_r  <= 8'(x_r);
          op_y_r  <= 8'(y_r);
          if (x_step > x_hi_r) begin
            x_r <= x_lo_r;
            y_r <= y_step;
            if (y_step > y_hi_r) begin
              state_r <= ST_FIN;
            end
          end else begin
            x_r <= x_step;
          end
        end
        ST_DIV: begin
          rem_x_r   <= {sub_x[11:0], 1'b0};
          rem_y_r   <= {sub_y[11:0], 1'b0};
          qx_r      <= qx_fin;
          qy_r      <= qy_fin;
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd1) begin
            ix_r    <= neg_x_r ? -32'(qx_fin) : 32'(qx_fin);
            iy_r    <= neg_y_r ? -32'(qy_fin) : 32'(qy_fin);
            state_r <= ST_LINE;
          end
        end
        ST_LINE: begin
          wr_en_r <= line_ok;
          op_x_r  <= 8'(rx);
          op_y_r  <= 8'(ry);
          px_r    <= px_r + ix_r;
          py_r    <= py_r + iy_r;
          cnt_r   <= cnt_r + 12'd1;
          if (cnt_r == side_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_RD_ADDR: begin
          state_r <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          res_color_r <= rd_ok_r ? rdata : 32'd0;
          state_r     <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_data_r.read_color <= res_color_r;
            out_data_r.done_res <= 1'b1;
            state_r             <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`include "framebuffer_draw_engine_macros.svh"

  `FDE_ASSERT(a_wr_in_frame, (wr_en_r |-> ((op_x_r < w_act) && (op_y_r < h_act))), "write outside frame")
  `FDE_NEVER(a_idle_no_write, ((state_r == ST_IDLE) && wr_en_r), "write pending while idle")
  `FDE_ASSERT(a_accept_setup, ((in_valid && in_ready) |=> (state_r == ST_SETUP)), "setup missed")
  `FDE_ASSERT(a_result_from_fin, ($rose(out_valid_r) |-> $past(state_r == ST_FIN)), "stray result")

endmodule
